### hw/rtl/rppr_pkg.sv
// shared types, constants and the frequency table builder for the rotary pair rotator
package rppr_pkg;

    localparam int unsigned PAIR_W    = 5;
    localparam int unsigned BF_W      = 16;
    localparam int unsigned MAX_PAIRS = 32;

    localparam logic [47:0] BASE_TURNS = 48'd44798133900094;
    localparam logic [31:0] RATIO_Q32  = 32'd3220771105;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

    localparam logic [15:0] BF_QNAN  = 16'h7FC0;
    localparam logic [15:0] BF_PINF  = 16'h7F80;
    localparam logic [15:0] BF_NINF  = 16'hFF80;
    localparam logic [15:0] BF_PZERO = 16'h0000;
    localparam logic [15:0] BF_NZERO = 16'h8000;

    typedef logic [MAX_PAIRS-1:0][47:0] t_freq_tab;

    // turns per position for each pair, one ratio step per entry
    function automatic t_freq_tab build_freq_tab();
        t_freq_tab  tab;
        logic [63:0] f;
        f = {16'b0, BASE_TURNS};
        for (int i = 0; i < int'(MAX_PAIRS); i++) begin
            tab[i] = f[47:0];
            f = ({32'b0, f[63:32]} * {32'b0, RATIO_Q32})
                + (({32'b0, f[31:0]} * {32'b0, RATIO_Q32}) >> 32);
        end
        return tab;
    endfunction

    // sideband carried alongside the datapath
    typedef struct packed {
        logic              bypass;
        logic              inverse;
        logic [PAIR_W-1:0] pair_index;
        logic [BF_W-1:0]   real_v;
        logic [BF_W-1:0]   imag_v;
    } t_side;

    // series evaluation state
    typedef struct packed {
        logic [2:0]  oct;
        logic [31:0] x;
        logic [31:0] x2;
        logic [32:0] s;
        logic [32:0] c;
    } t_horner;

    // sine and cosine as sign and Q1.16 magnitude
    typedef struct packed {
        logic [16:0] s_mag;
        logic        s_neg;
        logic [16:0] c_mag;
        logic        c_neg;
    } t_trig;

    typedef enum logic [1:0] {
        KIND_FIN,
        KIND_INF,
        KIND_NAN
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic               zero;
        logic [24:0]        m;
        logic signed [9:0]  e;
    } t_term;

    typedef struct packed {
        logic               done;
        logic [15:0]        bits;
        logic               neg;
        logic [27:0]        m;
        logic signed [9:0]  e;
    } t_sum;

endpackage

### hw/rtl/rppr_in_if.sv
// input channel: one pair with its position, index and direction
interface rppr_in_if #(parameter int POS_W = 20) ();
    logic                        valid;
    logic                        ready;
    logic [POS_W-1:0]            position;
    logic [rppr_pkg::PAIR_W-1:0] pair_index;
    logic [rppr_pkg::BF_W-1:0]   real_in;
    logic [rppr_pkg::BF_W-1:0]   imag_in;
    logic                        inverse;

    modport source (output valid, position, pair_index, real_in, imag_in, inverse,
                    input ready);
    modport sink (input valid, position, pair_index, real_in, imag_in, inverse,
                  output ready);
endinterface

### hw/rtl/rppr_out_if.sv
// output channel: rotated pair and its index
interface rppr_out_if ();
    logic                        valid;
    logic                        ready;
    logic [rppr_pkg::BF_W-1:0]   real_out;
    logic [rppr_pkg::BF_W-1:0]   imag_out;
    logic [rppr_pkg::PAIR_W-1:0] pair_index_out;

    modport source (output valid, real_out, imag_out, pair_index_out, input ready);
    modport sink (input valid, real_out, imag_out, pair_index_out, output ready);
endinterface

### hw/rtl/rotary_position_pair_rotate_core.sv
// rotary position pair rotator: top level with frequency lookup and pipeline control
//
//   channel  direction  transaction
//   i_in     sink       position, pair_index, real_in, imag_in, inverse
//   o_out    source     real_out, imag_out, pair_index_out
//
// one transaction per cycle while the output is not stalled; stages: 4 phase, 15 series, 2 trig, 5 combine
// the rate is set by the shared stall enable: every stage moves when the output
// register is empty or taken, so a stall holds the whole pipeline in place
// reset clears only the valid bits; payload registers hold no reset value
module rotary_position_pair_rotate_core #(
    parameter int ROTARY_PAIRS  = 32,
    parameter int POSITION_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rppr_in_if.sink    i_in,
    rppr_out_if.source o_out
);
    import rppr_pkg::*;

    localparam t_freq_tab FREQ_TAB = build_freq_tab();

    logic        en;
    t_side       in_side;
    logic        ph_valid;
    t_side       ph_side;
    logic [2:0]  ph_oct;
    logic [31:0] ph_x, ph_x2;
    logic        tr_valid;
    t_side       tr_side;
    t_trig       tr_trig;

    // pipeline advance
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // sideband at entry
    always_comb begin
        in_side.bypass     = int'(i_in.pair_index) >= ROTARY_PAIRS;
        in_side.inverse    = i_in.inverse;
        in_side.pair_index = i_in.pair_index;
        in_side.real_v     = i_in.real_in;
        in_side.imag_v     = i_in.imag_in;
    end

    rppr_phase #(
        .POSITION_BITS (POSITION_BITS)
    ) u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in.valid),
        .i_position (i_in.position),
        .i_freq     (FREQ_TAB[i_in.pair_index]),
        .i_side     (in_side),
        .o_valid    (ph_valid),
        .o_side     (ph_side),
        .o_oct      (ph_oct),
        .o_x        (ph_x),
        .o_x2       (ph_x2)
    );

    rppr_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ph_valid),
        .i_side  (ph_side),
        .i_oct   (ph_oct),
        .i_x     (ph_x),
        .i_x2    (ph_x2),
        .o_valid (tr_valid),
        .o_side  (tr_side),
        .o_trig  (tr_trig)
    );

    rppr_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (tr_valid),
        .i_side  (tr_side),
        .i_trig  (tr_trig),
        .o_valid (o_out.valid),
        .o_real  (o_out.real_out),
        .o_imag  (o_out.imag_out),
        .o_pair  (o_out.pair_index_out)
    );

    // a stalled pipeline keeps its inner valid bits
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(ph_valid) && $stable(tr_valid)))
        else $error("pipeline moved during stall");

    // sine and cosine magnitudes stay within one in Q1.16
    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tr_valid |-> (tr_trig.s_mag <= 17'd65536 && tr_trig.c_mag <= 17'd65536))
        else $error("trig magnitude out of range");

    // a fixed-point zero carries no sign
    a_zero_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tr_valid |-> (!(tr_trig.s_neg && tr_trig.s_mag == '0)
                      && !(tr_trig.c_neg && tr_trig.c_mag == '0)))
        else $error("signed zero from trig stage");

endmodule

### hw/rtl/rppr_phase.sv
// phase pipeline: position times frequency, octant fold, radians and square
module rppr_phase #(
    parameter int POSITION_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [POSITION_BITS-1:0] i_position,
    input  logic [47:0]              i_freq,
    input  rppr_pkg::t_side          i_side,
    output logic                     o_valid,
    output rppr_pkg::t_side          o_side,
    output logic [2:0]               o_oct,
    output logic [31:0]              o_x,
    output logic [31:0]              o_x2
);
    import rppr_pkg::*;

    logic [3:0]  r_v;
    t_side       r_sd [4];
    logic [47:0] r_p0;
    logic [31:0] r_p1;
    logic [15:0] r_p2;
    logic [29:0] r_rem;
    logic [2:0]  r_oct2, r_oct3, r_oct4;
    logic [31:0] r_x3, r_x4, r_x2;

    logic [31:0] pos32;
    logic [47:0] n_p0;
    logic [31:0] n_p1;
    logic [15:0] n_p2;
    logic [47:0] ph;
    logic [45:0] rem46;
    logic [61:0] xp;
    logic [63:0] sq;

    // partial products of the phase, kept modulo one turn
    assign pos32 = 32'(i_position);
    assign n_p0  = {16'b0, pos32} * {32'b0, i_freq[15:0]};
    assign n_p1  = pos32 * {16'b0, i_freq[31:16]};
    assign n_p2  = pos32[15:0] * i_freq[47:32];

    // sum, octant select and reflection in odd octants
    always_comb begin
        ph    = r_p0 + {r_p1, 16'b0} + {r_p2, 32'b0};
        rem46 = {1'b0, ph[44:0]};
        if (ph[45]) begin
            rem46 = 46'h2000_0000_0000 - {1'b0, ph[44:0]};
        end
    end

    // turns to radians, then the square
    assign xp = {32'b0, r_rem} * {30'b0, TWO_PI_Q29};
    assign sq = {32'b0, r_x3} * {32'b0, r_x3};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int i = 1; i < 4; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            r_p0   <= n_p0;
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_rem  <= rem46[45:16];
            r_oct2 <= ph[47:45];
            r_x3   <= xp[60:29];
            r_oct3 <= r_oct2;
            r_x2   <= sq[63:32];
            r_x4   <= r_x3;
            r_oct4 <= r_oct3;
        end
    end

    assign o_valid = r_v[3];
    assign o_side  = r_sd[3];
    assign o_oct   = r_oct4;
    assign o_x     = r_x4;
    assign o_x2    = r_x2;

endmodule

### hw/rtl/rppr_horner_step.sv
// one series step for sine and cosine lanes: multiply, reciprocal divide, correct
module rppr_horner_step #(
    parameter int DIV_S = 0,
    parameter int DIV_C = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rppr_pkg::t_horner i_h,
    input  rppr_pkg::t_side   i_side,
    output logic              o_valid,
    output rppr_pkg::t_horner o_h,
    output rppr_pkg::t_side   o_side
);
    import rppr_pkg::*;

    logic [2:0] r_v;
    t_side      r_sd [3];
    t_horner    r_ha, r_hb, r_hc;
    t_horner    n_hc;

    logic [32:0] w_in  [2];
    logic [32:0] w_b   [2];
    logic [32:0] n_res [2];

    assign w_in[0] = i_h.s;
    assign w_in[1] = i_h.c;
    assign w_b[0]  = r_hb.s;
    assign w_b[1]  = r_hb.c;

    // per lane: one minus (x2 * v) / divisor, or pass when divisor is zero
    for (genvar l = 0; l < 2; l++) begin : g_lane
        localparam int D  = (l == 0) ? DIV_S : DIV_C;
        localparam int DD = (D == 0) ? 1 : D;
        localparam logic [33:0] M = 34'((64'd1 << 34) / DD);

        logic [31:0] r_pa, r_pb, r_qb;
        logic [63:0] prod_a;
        logic [65:0] prod_b;
        logic [38:0] qd, rem39;
        logic [31:0] q;

        assign prod_a = {31'b0, w_in[l]} * {32'b0, i_h.x2};
        assign prod_b = {34'b0, r_pa} * {32'b0, M};
        assign qd     = {7'b0, r_qb} * 39'(DD);
        assign rem39  = {7'b0, r_pb} - qd;
        assign q      = r_qb + ((rem39 >= 39'(DD)) ? 32'd1 : 32'd0);
        assign n_res[l] = (D == 0) ? w_b[l] : (ONE_Q32 - {1'b0, q});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa <= prod_a[63:32];
                r_pb <= r_pa;
                r_qb <= prod_b[65:34];
            end
        end
    end

    // next carried state with the updated lanes
    always_comb begin
        n_hc   = r_hb;
        n_hc.s = n_res[0];
        n_hc.c = n_res[1];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // carried state
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            r_sd[1] <= r_sd[0];
            r_sd[2] <= r_sd[1];
            r_ha    <= i_h;
            r_hb    <= r_ha;
            r_hc    <= n_hc;
        end
    end

    assign o_valid = r_v[2];
    assign o_h     = r_hc;
    assign o_side  = r_sd[2];

endmodule

### hw/rtl/rppr_trig.sv
// sine and cosine from the folded angle: series chain, final multiply, octant map
module rppr_trig (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rppr_pkg::t_side i_side,
    input  logic [2:0]      i_oct,
    input  logic [31:0]     i_x,
    input  logic [31:0]     i_x2,
    output logic            o_valid,
    output rppr_pkg::t_side o_side,
    output rppr_pkg::t_trig o_trig
);
    import rppr_pkg::*;

    localparam int STEPS = 5;
    localparam int DIV_S_TAB [STEPS] = '{0, 72, 42, 20, 6};
    localparam int DIV_C_TAB [STEPS] = '{90, 56, 30, 12, 2};

    logic    st_v  [STEPS+1];
    t_horner st_h  [STEPS+1];
    t_side   st_sd [STEPS+1];

    logic [1:0]  r_v;
    t_side       r_sd [2];
    logic [31:0] r_fs;
    logic [32:0] r_fc;
    logic [2:0]  r_foct;
    t_trig       r_trig;

    logic [64:0] sp;
    logic [32:0] s_rnd;
    logic [33:0] c_rnd;
    logic [16:0] s16, c16;
    logic        swap;
    t_trig       n_trig;

    // series start at one
    always_comb begin
        st_h[0]     = '0;
        st_h[0].oct = i_oct;
        st_h[0].x   = i_x;
        st_h[0].x2  = i_x2;
        st_h[0].s   = ONE_Q32;
        st_h[0].c   = ONE_Q32;
    end
    assign st_v[0]  = i_valid;
    assign st_sd[0] = i_side;

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        rppr_horner_step #(
            .DIV_S (DIV_S_TAB[j]),
            .DIV_C (DIV_C_TAB[j])
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (st_v[j]),
            .i_h     (st_h[j]),
            .i_side  (st_sd[j]),
            .o_valid (st_v[j+1]),
            .o_h     (st_h[j+1]),
            .o_side  (st_sd[j+1])
        );
    end

    // sine gets its final factor of x
    assign sp = {33'b0, st_h[STEPS].x} * {32'b0, st_h[STEPS].s};

    // round to Q1.16, map by octant symmetry and negate the sine for the inverse direction
    always_comb begin
        s_rnd = {1'b0, r_fs} + 33'd32768;
        c_rnd = {1'b0, r_fc} + 34'd32768;
        s16   = s_rnd[32:16];
        c16   = c_rnd[32:16];
        swap  = r_foct[0] ^ r_foct[1];
        n_trig.s_mag = swap ? c16 : s16;
        n_trig.c_mag = swap ? s16 : c16;
        n_trig.s_neg = (r_foct[2] ^ r_sd[0].inverse) && (n_trig.s_mag != '0);
        n_trig.c_neg = (r_foct[1] ^ r_foct[2]) && (n_trig.c_mag != '0);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], st_v[STEPS]};
        end
    end

    // final stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= st_sd[STEPS];
            r_sd[1] <= r_sd[0];
            r_fs    <= sp[63:32];
            r_fc    <= st_h[STEPS].c;
            r_foct  <= st_h[STEPS].oct;
            r_trig  <= n_trig;
        end
    end

    assign o_valid = r_v[1];
    assign o_side  = r_sd[1];
    assign o_trig  = r_trig;

endmodule

### hw/rtl/rppr_combine.sv
// products, exact sums and bfloat16 rounding for both outputs
module rppr_combine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rppr_pkg::t_side             i_side,
    input  rppr_pkg::t_trig             i_trig,
    output logic                        o_valid,
    output logic [rppr_pkg::BF_W-1:0]   o_real,
    output logic [rppr_pkg::BF_W-1:0]   o_imag,
    output logic [rppr_pkg::PAIR_W-1:0] o_pair
);
    import rppr_pkg::*;

    // bf16 times signed Q1.16, exact, not yet normalized
    function automatic t_term make_term(logic [15:0] bf, logic [16:0] mag, logic qneg);
        t_term      t;
        logic [7:0] ex;
        logic [7:0] mant;
        ex   = bf[14:7];
        mant = (ex == 8'd0) ? {1'b0, bf[6:0]} : {1'b1, bf[6:0]};
        t.neg  = bf[15] ^ qneg;
        t.m    = {17'b0, mant} * {8'b0, mag};
        t.zero = (t.m == '0);
        t.e    = (ex == 8'd0) ? -10'sd149 : ($signed({2'b0, ex}) - 10'sd150);
        if (ex == 8'hFF) begin
            t.kind = ((bf[6:0] != '0) || (mag == '0)) ? KIND_NAN : KIND_INF;
        end else begin
            t.kind = KIND_FIN;
        end
        return t;
    endfunction

    function automatic logic [4:0] lzc25(logic [24:0] v);
        logic [4:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = 24; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else n = n + 5'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc28(logic [27:0] v);
        logic [4:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else n = n + 5'd1;
            end
        end
        return n;
    endfunction

    function automatic t_term norm_term(t_term t);
        t_term      r;
        logic [4:0] lz;
        r  = t;
        lz = lzc25(t.m);
        if (!t.zero) begin
            r.m = t.m << lz;
            r.e = t.e - $signed({5'b0, lz});
        end
        return r;
    endfunction

    // aligned add with sticky jam, or the special result
    function automatic t_sum add_terms(t_term a, t_term b);
        t_sum               r;
        t_term              big, sml;
        logic signed [10:0] d;
        logic [27:0]        av;
        logic [26:0]        bext, bv;
        logic               sticky;
        r      = '0;
        big    = a;
        sml    = b;
        bv     = '0;
        sticky = 1'b0;
        if (a.kind == KIND_NAN || b.kind == KIND_NAN) begin
            r.done = 1'b1;
            r.bits = BF_QNAN;
        end else if (a.kind == KIND_INF && b.kind == KIND_INF) begin
            r.done = 1'b1;
            r.bits = (a.neg != b.neg) ? BF_QNAN : (a.neg ? BF_NINF : BF_PINF);
        end else if (a.kind == KIND_INF) begin
            r.done = 1'b1;
            r.bits = a.neg ? BF_NINF : BF_PINF;
        end else if (b.kind == KIND_INF) begin
            r.done = 1'b1;
            r.bits = b.neg ? BF_NINF : BF_PINF;
        end else if (a.zero && b.zero) begin
            r.done = 1'b1;
            r.bits = (a.neg && b.neg) ? BF_NZERO : BF_PZERO;
        end else begin
            if (a.zero || (!b.zero && ($signed(b.e) > $signed(a.e)))) begin
                big = b;
                sml = a;
            end
            d    = {big.e[9], big.e} - {sml.e[9], sml.e};
            av   = {1'b0, big.m, 2'b0};
            bext = {sml.m, 2'b0};
            if (!sml.zero) begin
                if (d >= 11'sd27) begin
                    bv = 27'd1;
                end else begin
                    bv     = bext >> d[4:0];
                    sticky = |(bext & ~(27'h7FF_FFFF << d[4:0]));
                    bv[0]  = bv[0] | sticky;
                end
            end
            r.e = big.e;
            if (big.neg == sml.neg) begin
                r.m   = av + {1'b0, bv};
                r.neg = big.neg;
            end else if (av >= {1'b0, bv}) begin
                r.m   = av - {1'b0, bv};
                r.neg = big.neg;
            end else begin
                r.m   = {1'b0, bv} - av;
                r.neg = sml.neg;
            end
            if (r.m == '0) begin
                r.done = 1'b1;
                r.bits = BF_PZERO;
            end
        end
        return r;
    endfunction

    // nearest even rounding of a normalized 28-bit window, subnormals included
    function automatic logic [15:0] round_pack(logic neg, logic [27:0] m,
                                               logic signed [10:0] eu);
        logic [7:0]  sh;
        logic [28:0] m29, rr, half;
        logic [8:0]  q;
        logic [10:0] ebias;
        logic [16:0] b17;
        m29   = {1'b0, m};
        ebias = 11'(eu + 11'sd126);
        rr    = '0;
        half  = '0;
        if (eu >= -11'sd126) sh = 8'd20;
        else sh = 8'(-11'sd106 - eu);
        if (sh >= 8'd29) begin
            q = '0;
        end else begin
            q    = 9'(m29 >> sh);
            rr   = m29 & ((29'd1 << sh) - 29'd1);
            half = 29'd1 << (sh - 8'd1);
            if (rr > half || (rr == half && q[0])) q = q + 9'd1;
        end
        if (eu >= -11'sd126) b17 = {2'b0, ebias[7:0], 7'b0} + {8'b0, q};
        else b17 = {8'b0, q};
        if (b17 >= 17'h07F80) b17 = 17'h07F80;
        return {neg, b17[14:0]};
    endfunction

    logic [4:0] r_v;
    t_side      r_sd [5];
    t_term      r_t1 [4];
    t_term      r_t2 [4];
    t_sum       r_s3 [2];
    t_sum       r_s4 [2];
    logic signed [10:0] r_eu [2];
    logic [15:0] r_re, r_im;

    t_term n_t1 [4];
    t_sum  n_s4 [2];
    logic signed [10:0] n_eu [2];
    logic [4:0] lz [2];

    // products: re*c, -(im*s), re*s, im*c
    assign n_t1[0] = make_term(i_side.real_v, i_trig.c_mag, i_trig.c_neg);
    assign n_t1[1] = make_term(i_side.imag_v, i_trig.s_mag, !i_trig.s_neg);
    assign n_t1[2] = make_term(i_side.real_v, i_trig.s_mag, i_trig.s_neg);
    assign n_t1[3] = make_term(i_side.imag_v, i_trig.c_mag, i_trig.c_neg);

    // sum normalization
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            lz[k]   = lzc28(r_s3[k].m);
            n_s4[k] = r_s3[k];
            n_s4[k].m = r_s3[k].m << lz[k];
            n_eu[k] = {r_s3[k].e[9], r_s3[k].e} + 11'sd25 - $signed({6'b0, lz[k]});
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int i = 1; i < 5; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            for (int k = 0; k < 4; k++) begin
                r_t1[k] <= n_t1[k];
                r_t2[k] <= norm_term(r_t1[k]);
            end
            r_s3[0] <= add_terms(r_t2[0], r_t2[1]);
            r_s3[1] <= add_terms(r_t2[2], r_t2[3]);
            r_s4    <= n_s4;
            r_eu    <= n_eu;
            if (r_sd[3].bypass) begin
                r_re <= r_sd[3].real_v;
                r_im <= r_sd[3].imag_v;
            end else begin
                r_re <= r_s4[0].done ? r_s4[0].bits
                                     : round_pack(r_s4[0].neg, r_s4[0].m, r_eu[0]);
                r_im <= r_s4[1].done ? r_s4[1].bits
                                     : round_pack(r_s4[1].neg, r_s4[1].m, r_eu[1]);
            end
        end
    end

    assign o_valid = r_v[4];
    assign o_real  = r_re;
    assign o_imag  = r_im;
    assign o_pair  = r_sd[4].pair_index;

endmodule

### bench/tb_rotary_position_pair_rotate_core.sv
// testbench for the rotary pair rotator: predicts each rotated pair and checks the output stream
`timescale 1ns / 1ps

module tb_rotary_position_pair_rotate_core;
    import rppr_pkg::*;

    localparam int N_PAIRS = 32;
    localparam int POS_BITS = 20;
    localparam int LATENCY = 26;

    typedef struct {
        logic [19:0] position;
        logic [4:0]  pair_index;
        logic [15:0] real_in;
        logic [15:0] imag_in;
        logic        inverse;
    } t_pair_in;

    typedef struct {
        logic [15:0] real_out;
        logic [15:0] imag_out;
        logic [4:0]  pair_index_out;
    } t_pair_out;

    // product term: kind, sign and a 48-bit normalized magnitude
    typedef struct {
        t_kind       kind;
        logic        neg;
        logic [63:0] m;
        int          e;
    } t_prod;

    logic i_clk;
    logic i_rst_n;
    rppr_in_if #(.POS_W(POS_BITS)) in_ch ();
    rppr_out_if out_ch ();

    rotary_position_pair_rotate_core #(
        .ROTARY_PAIRS (N_PAIRS),
        .POSITION_BITS(POS_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_pair_in  pending_pairs[$];
    t_pair_out rotated_expect[$];
    logic [47:0] turns_per_pos[N_PAIRS];
    int  n_errors = 0;
    int  n_checked = 0;
    int  n_sent = 0;
    bit  hold_sender;
    int  send_gap;
    int  take_gap;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // frequency table, one ratio step per pair
    initial begin
        logic [63:0] f;
        f = 64'd44798133900094;
        for (int i = 0; i < N_PAIRS; i++) begin
            turns_per_pos[i] = f[47:0];
            f = (f >> 32) * 64'd3220771105 + (((f & 64'hFFFF_FFFF) * 64'd3220771105) >> 32);
        end
    end

    function automatic int msb_pos(logic [63:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) p = i;
        return p;
    endfunction

    function automatic logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return p[95:32];
    endfunction

    // sine and cosine of a phase in turns, Q1.16 signed
    function automatic void phase_trig(input logic [47:0] ph, output int sv, output int cv);
        logic [2:0]  oct;
        logic [63:0] rem, x, x2, s, c, one;
        int s16, c16;
        one = 64'h1_0000_0000;
        oct = ph[47:45];
        rem = {19'd0, ph[44:0]};
        if (oct[0]) rem = (64'd1 << 45) - rem;
        x = ((rem >> 16) * 64'd3373259426) >> 29;
        x2 = q32_mul(x, x);
        s = one;
        s = one - q32_mul(x2, s) / 72;
        s = one - q32_mul(x2, s) / 42;
        s = one - q32_mul(x2, s) / 20;
        s = one - q32_mul(x2, s) / 6;
        s = q32_mul(x, s);
        c = one;
        c = one - q32_mul(x2, c) / 90;
        c = one - q32_mul(x2, c) / 56;
        c = one - q32_mul(x2, c) / 30;
        c = one - q32_mul(x2, c) / 12;
        c = one - q32_mul(x2, c) / 2;
        s16 = int'((s + 64'd32768) >> 16);
        c16 = int'((c + 64'd32768) >> 16);
        case (oct)
            3'd0: begin sv = s16;  cv = c16;  end
            3'd1: begin sv = c16;  cv = s16;  end
            3'd2: begin sv = c16;  cv = -s16; end
            3'd3: begin sv = s16;  cv = -c16; end
            3'd4: begin sv = -s16; cv = -c16; end
            3'd5: begin sv = -c16; cv = -s16; end
            3'd6: begin sv = -c16; cv = s16;  end
            default: begin sv = -s16; cv = c16; end
        endcase
    endfunction

    // exact product of a bfloat16 and a Q1.16 value
    function automatic t_prod bf_times_q(logic [15:0] bf, int q);
        t_prod t;
        logic [7:0]  ex;
        logic [6:0]  man;
        logic [63:0] uq, mant;
        int e, sh;
        ex = bf[14:7];
        man = bf[6:0];
        uq = (q < 0) ? 64'(-q) : 64'(q);
        t.neg = bf[15] ^ (q < 0);
        t.m = 0;
        t.e = 0;
        if (ex == 8'hFF) begin
            t.kind = (man != 0 || uq == 0) ? KIND_NAN : KIND_INF;
            return t;
        end
        t.kind = KIND_FIN;
        if (ex == 0) begin mant = {57'd0, man}; e = -126; end
        else begin mant = {56'd0, 1'b1, man}; e = int'(ex) - 127; end
        t.m = mant * uq;
        if (t.m == 0) return t;
        sh = 47 - msb_pos(t.m);
        t.m = t.m << sh;
        t.e = e - 23 - sh;
        return t;
    endfunction

    // round a magnitude to bfloat16, nearest even, with subnormals
    function automatic logic [15:0] to_bf16(logic neg, logic [63:0] m, int e);
        int eu, lsb, sh;
        logic [63:0] q, r, half;
        logic [31:0] bits;
        eu = msb_pos(m) + e;
        lsb = ((eu >= -126) ? eu : -126) - 7;
        sh = lsb - e;
        if (sh > 0) begin
            if (sh >= 64) q = 0;
            else begin
                q = m >> sh;
                r = m & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                if (r > half || (r == half && q[0])) q++;
            end
        end else q = m << (-sh);
        if (eu >= -126) bits = (32'(eu + 126) << 7) + q[31:0];
        else bits = q[31:0];
        if (bits >= 32'h7F80) bits = 32'h7F80;
        return bits[15:0] | (neg ? BF_NZERO : BF_PZERO);
    endfunction

    function automatic logic [15:0] sum_terms(t_prod a, t_prod b);
        t_prod t;
        logic [63:0] mb, m;
        int d;
        logic neg;
        if (a.kind == KIND_NAN || b.kind == KIND_NAN) return BF_QNAN;
        if (a.kind == KIND_INF && b.kind == KIND_INF)
            return (a.neg != b.neg) ? BF_QNAN : (a.neg ? BF_NINF : BF_PINF);
        if (a.kind == KIND_INF) return a.neg ? BF_NINF : BF_PINF;
        if (b.kind == KIND_INF) return b.neg ? BF_NINF : BF_PINF;
        if (a.m == 0 && b.m == 0) return (a.neg && b.neg) ? BF_NZERO : BF_PZERO;
        if (a.m == 0) return to_bf16(b.neg, b.m, b.e);
        if (b.m == 0) return to_bf16(a.neg, a.m, a.e);
        if (b.e > a.e) begin t = a; a = b; b = t; end
        d = a.e - b.e;
        if (d >= 64) mb = 1;
        else if (d == 0) mb = b.m;
        else mb = (b.m >> d) | 64'((b.m & ((64'd1 << d) - 1)) != 0);
        if (a.neg == b.neg) begin m = a.m + mb; neg = a.neg; end
        else if (a.m >= mb) begin m = a.m - mb; neg = a.neg; end
        else begin m = mb - a.m; neg = b.neg; end
        if (m == 0) return BF_PZERO;
        return to_bf16(neg, m, a.e);
    endfunction

    // expected rotated pair for one input transaction
    function automatic t_pair_out rotate_pair(t_pair_in p);
        t_pair_out r;
        logic [67:0] prod;
        int s, c;
        t_prod t1, t2;
        r.pair_index_out = p.pair_index;
        if (p.pair_index >= N_PAIRS) begin
            r.real_out = p.real_in;
            r.imag_out = p.imag_in;
            return r;
        end
        prod = p.position * turns_per_pos[p.pair_index];
        phase_trig(prod[47:0], s, c);
        if (p.inverse) s = -s;
        t1 = bf_times_q(p.real_in, c);
        t2 = bf_times_q(p.imag_in, s);
        t2.neg = ~t2.neg;
        r.real_out = sum_terms(t1, t2);
        t1 = bf_times_q(p.real_in, s);
        t2 = bf_times_q(p.imag_in, c);
        r.imag_out = sum_terms(t1, t2);
        return r;
    endfunction

    function automatic logic [15:0] rand_bf16();
        case ($urandom_range(0, 9))
            0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 7'($urandom_range(0, 1) ?
                       $urandom : 0)};
            1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'h00, 7'($urandom)};
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFE, 7'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_pair(logic [19:0] pos, logic [4:0] k, logic [15:0] re,
                              logic [15:0] im, logic inv);
        t_pair_in p;
        p.position = pos;
        p.pair_index = k;
        p.real_in = re;
        p.imag_in = im;
        p.inverse = inv;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    // reset and stimulus
    initial begin
        hold_sender = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: field extremes, specials and both directions
        queue_pair(20'd0, 5'd0, 16'h3F80, 16'h0000, 1'b0);
        queue_pair(20'hFFFFF, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_pair(20'd1, 5'd0, 16'h3F80, 16'h3F80, 1'b0);
        queue_pair(20'd1, 5'd0, 16'h3F80, 16'h3F80, 1'b1);
        queue_pair(20'd7, 5'd3, 16'h7FC1, 16'h3F80, 1'b0);
        queue_pair(20'd7, 5'd3, 16'h7F80, 16'h3F80, 1'b0);
        queue_pair(20'd7, 5'd3, 16'hFF80, 16'h7F80, 1'b1);
        queue_pair(20'd0, 5'd0, 16'h7F80, 16'h7F80, 1'b0);
        queue_pair(20'd0, 5'd0, 16'h0000, 16'h8000, 1'b0);
        queue_pair(20'd0, 5'd0, 16'h8000, 16'h8000, 1'b0);
        queue_pair(20'd100, 5'd1, 16'h7F7F, 16'h7F7F, 1'b0);
        queue_pair(20'd5, 5'd2, 16'h0001, 16'h807F, 1'b1);
        queue_pair(20'd12345, 5'd16, 16'h0080, 16'h8080, 1'b0);
        queue_pair(20'hAAAAA, 5'd10, 16'h5555, 16'hAAAA, 1'b1);
        queue_pair(20'h55555, 5'd21, 16'hAAAA, 16'h5555, 1'b0);
        queue_pair(20'd3, 5'd0, 16'h4000, 16'hC000, 1'b0);
        for (int i = 0; i < 600; i++) begin
            queue_pair($urandom_range(0, 3) == 0 ? 20'($urandom_range(0, 64)) : 20'($urandom),
                       5'($urandom), rand_bf16(), rand_bf16(), 1'($urandom));
            if (i % 50 == 0) @(posedge i_clk);
        end
        // partway through, hold the sender until every result is back
        do begin @(posedge i_clk); #1; end while (pending_pairs.size() > 300);
        hold_sender = 1'b1;
        do begin @(posedge i_clk); #1; end
        while (in_ch.valid || rotated_expect.size() != 0);
        hold_sender = 1'b0;
        // wait for the rest to be sent and checked
        do begin @(posedge i_clk); #1; end
        while (pending_pairs.size() != 0 || in_ch.valid || rotated_expect.size() != 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d pair transactions, %0d results checked, both directions,",
                 n_sent, n_checked);
        $display("special values, subnormals and all pair indexes");
        if (n_errors == 0 && rotated_expect.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // driver: one transaction at a time with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.position <= '0;
            in_ch.pair_index <= '0;
            in_ch.real_in <= '0;
            in_ch.imag_in <= '0;
            in_ch.inverse <= 1'b0;
            send_gap <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the transaction until taken
        end else begin
            if (in_ch.valid) begin
                rotated_expect.insert(rotated_expect.size(),
                                      rotate_pair('{in_ch.position, in_ch.pair_index,
                                      in_ch.real_in, in_ch.imag_in, in_ch.inverse}));
                n_sent++;
            end
            if (send_gap > 0 || hold_sender || pending_pairs.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                t_pair_in p;
                p = pending_pairs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.position <= p.position;
                in_ch.pair_index <= p.pair_index;
                in_ch.real_in <= p.real_in;
                in_ch.imag_in <= p.imag_in;
                in_ch.inverse <= p.inverse;
                send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            end
        end
    end

    // monitor: random stalls, check each result against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            take_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (rotated_expect.size() == 0) begin
                    $display("%0t: unexpected result real %h imag %h pair %0d", $realtime,
                             out_ch.real_out, out_ch.imag_out, out_ch.pair_index_out);
                    n_errors++;
                end else begin
                    t_pair_out x;
                    x = rotated_expect.pop_front();
                    n_checked++;
                    if (out_ch.real_out !== x.real_out) begin
                        $display("%0t: real_out expected %h actual %h", $realtime,
                                 x.real_out, out_ch.real_out);
                        n_errors++;
                    end
                    if (out_ch.imag_out !== x.imag_out) begin
                        $display("%0t: imag_out expected %h actual %h", $realtime,
                                 x.imag_out, out_ch.imag_out);
                        n_errors++;
                    end
                    if (out_ch.pair_index_out !== x.pair_index_out) begin
                        $display("%0t: pair_index_out expected %0d actual %0d", $realtime,
                                 x.pair_index_out, out_ch.pair_index_out);
                        n_errors++;
                    end
                end
            end
            if (take_gap > 0) begin
                out_ch.ready <= 1'b0;
                take_gap <= take_gap - 1;
            end else begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid && out_ch.ready)
                    take_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            end
        end
    end

    // timeout
    initial begin
        #(12 * 200000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rppr_pkg.sv
hw/rtl/rppr_in_if.sv
hw/rtl/rppr_out_if.sv
hw/rtl/rppr_phase.sv
hw/rtl/rppr_horner_step.sv
hw/rtl/rppr_trig.sv
hw/rtl/rppr_combine.sv
hw/rtl/rotary_position_pair_rotate_core.sv
bench/tb_rotary_position_pair_rotate_core.sv
